>>> sv/transient_shaper_assert.svh
// assertion macros shared by the transient shaper checker
// no dependencies; included by bare file name
`ifndef TRANSIENT_SHAPER_ASSERT_SVH
`define TRANSIENT_SHAPER_ASSERT_SVH

// same-cycle implication, off during reset
`define TS_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TS_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TS_ASSERT_ALWAYS_NXT(label, ck, ante, cons, msg) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ts_pkg.sv
// shared types, constants and microcode program of the transient shaper
// no dependencies; used by every other file but the assertion header, by scoped names
package ts_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int CHAN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COEF_W      = 16;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [COEF_W-1:0] RST_FAST_ATT = 16'd62466;
  localparam logic [COEF_W-1:0] RST_FAST_REL = 16'd65467;
  localparam logic [COEF_W-1:0] RST_SLOW_ATT = 16'd65399;
  localparam logic [COEF_W-1:0] RST_SLOW_REL = 16'd65529;
  localparam logic [COEF_W-1:0] RST_AMOUNT   = 16'd0;

  typedef enum logic [2:0] {
    REG_FAST_ATT = 3'd0,
    REG_FAST_REL = 3'd1,
    REG_SLOW_ATT = 3'd2,
    REG_SLOW_REL = 3'd3,
    REG_AMOUNT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] fast_att;
    logic [COEF_W-1:0] fast_rel;
    logic [COEF_W-1:0] slow_att;
    logic [COEF_W-1:0] slow_rel;
    logic [COEF_W-1:0] amount;
  } coef_t;

  // multiplier operand selects
  typedef enum logic [1:0] {
    A_FAST_ERR,
    A_SLOW_ERR,
    A_ENV_DIFF,
    A_GAIN
  } a_sel_t;

  typedef enum logic [1:0] {
    B_FAST_COEF,
    B_SLOW_COEF,
    B_AMOUNT,
    B_SAMPLE
  } b_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_FAST,
    WB_SLOW,
    WB_GAIN,
    WB_OUT,
    WB_PASS
  } wb_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ACCEPT,
    JMP_HOME
  } jmp_t;

  localparam int STEP_W    = 4;
  localparam int PROG_LEN  = 9;
  localparam logic [STEP_W-1:0] STEP_PASS = 4'd8;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    wb_t               wb;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic chan_ok;
    logic out_blocked;
  } dp_status_t;

  // one control word per step; the multiply of a step is written back one step later
  localparam ctl_t PROG [PROG_LEN] = '{
    '{A_FAST_ERR, B_FAST_COEF, 1'b0, WB_NONE, JMP_ACCEPT, STEP_PASS},
    '{A_FAST_ERR, B_FAST_COEF, 1'b1, WB_NONE, JMP_NEXT,   4'd0},
    '{A_SLOW_ERR, B_SLOW_COEF, 1'b1, WB_FAST, JMP_NEXT,   4'd0},
    '{A_SLOW_ERR, B_SLOW_COEF, 1'b0, WB_SLOW, JMP_NEXT,   4'd0},
    '{A_ENV_DIFF, B_AMOUNT,    1'b1, WB_NONE, JMP_NEXT,   4'd0},
    '{A_ENV_DIFF, B_AMOUNT,    1'b0, WB_GAIN, JMP_NEXT,   4'd0},
    '{A_GAIN,     B_SAMPLE,    1'b1, WB_NONE, JMP_NEXT,   4'd0},
    '{A_GAIN,     B_SAMPLE,    1'b0, WB_OUT,  JMP_HOME,   4'd0},
    '{A_GAIN,     B_SAMPLE,    1'b0, WB_PASS, JMP_HOME,   4'd0}
  };

endpackage

>>> sv/ts_chan_if.sv
// valid/ready channel interfaces for samples in and shaped samples out
// depends on ts_pkg for default widths
interface ts_in_if #(
  parameter int CHAN_W = ts_pkg::CHAN_W,
  parameter int SW     = ts_pkg::SAMPLE_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_W-1:0]    chan;
  logic signed [SW-1:0] sample_in;

  modport source (output valid, chan, sample_in, input ready);
  modport sink   (input valid, chan, sample_in, output ready);
endinterface

interface ts_out_if #(
  parameter int CHAN_W = ts_pkg::CHAN_W,
  parameter int SW     = ts_pkg::SAMPLE_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_W-1:0]    chan_out;
  logic signed [SW-1:0] sample_out;

  modport source (output valid, chan_out, sample_out, input ready);
  modport sink   (input valid, chan_out, sample_out, output ready);
endinterface

>>> sv/ts_regs.sv
// apb-style configuration registers: envelope poles and shaping amount
// depends on ts_pkg
module ts_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ts_pkg::ADDR_W-1:0]   paddr,
  input  logic [ts_pkg::DATA_W-1:0]   pwdata,
  output logic [ts_pkg::DATA_W-1:0]   prdata,
  output logic                        pready,
  output ts_pkg::coef_t               coef
);

  ts_pkg::coef_t     coef_r;
  ts_pkg::coef_t     coef_nxt;
  ts_pkg::reg_idx_t  idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ts_pkg::reg_idx_t'(paddr[ts_pkg::ADDR_W-1:2]);
  assign coef   = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      case (idx)
        ts_pkg::REG_FAST_ATT: coef_nxt.fast_att = pwdata[ts_pkg::COEF_W-1:0];
        ts_pkg::REG_FAST_REL: coef_nxt.fast_rel = pwdata[ts_pkg::COEF_W-1:0];
        ts_pkg::REG_SLOW_ATT: coef_nxt.slow_att = pwdata[ts_pkg::COEF_W-1:0];
        ts_pkg::REG_SLOW_REL: coef_nxt.slow_rel = pwdata[ts_pkg::COEF_W-1:0];
        ts_pkg::REG_AMOUNT:   coef_nxt.amount   = pwdata[ts_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ts_pkg::REG_FAST_ATT: prdata = ts_pkg::DATA_W'(coef_r.fast_att);
      ts_pkg::REG_FAST_REL: prdata = ts_pkg::DATA_W'(coef_r.fast_rel);
      ts_pkg::REG_SLOW_ATT: prdata = ts_pkg::DATA_W'(coef_r.slow_att);
      ts_pkg::REG_SLOW_REL: prdata = ts_pkg::DATA_W'(coef_r.slow_rel);
      ts_pkg::REG_AMOUNT:   prdata = ts_pkg::DATA_W'(coef_r.amount);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.fast_att <= ts_pkg::RST_FAST_ATT;
      coef_r.fast_rel <= ts_pkg::RST_FAST_REL;
      coef_r.slow_att <= ts_pkg::RST_SLOW_ATT;
      coef_r.slow_rel <= ts_pkg::RST_SLOW_REL;
      coef_r.amount   <= ts_pkg::RST_AMOUNT;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

>>> sv/ts_seq.sv
// microcode sequencer: step counter, program fetch and jumps
// depends on ts_pkg (control word, program table)
module ts_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  ts_pkg::dp_status_t status,
  output ts_pkg::ctl_t       ctl
);

  logic [ts_pkg::STEP_W-1:0] step_r;
  logic [ts_pkg::STEP_W-1:0] step_nxt;
  logic                      hold;

  assign ctl = ts_pkg::PROG[step_r];

  // a result step waits while the output register is still full and not taken
  assign hold = status.out_blocked && (ctl.wb inside {ts_pkg::WB_OUT, ts_pkg::WB_PASS});

  always_comb begin
    step_nxt = step_r;
    case (ctl.jmp)
      ts_pkg::JMP_ACCEPT: begin
        if (status.in_fire) begin
          step_nxt = status.chan_ok ? ts_pkg::STEP_W'(step_r + 1'b1) : ctl.target;
        end
      end
      ts_pkg::JMP_NEXT: begin
        if (!hold) step_nxt = ts_pkg::STEP_W'(step_r + 1'b1);
      end
      ts_pkg::JMP_HOME: begin
        if (!hold) step_nxt = '0;
      end
      default: step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> sv/ts_datapath.sv
// datapath: shared multiplier, per-channel envelopes, rounding and output register
// depends on ts_pkg and the channel interfaces
module ts_datapath #(
  parameter int CHANNELS    = ts_pkg::CHANNELS,
  parameter int SAMPLE_BITS = ts_pkg::SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  ts_in_if.sink              in_bus,
  ts_out_if.source           out_bus,
  input  ts_pkg::coef_t      coef,
  input  ts_pkg::ctl_t       ctl,
  output ts_pkg::dp_status_t status
);

  localparam int SW     = SAMPLE_BITS;
  localparam int EW     = SW - 1;
  localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW     = (SW > ts_pkg::COEF_W + 1) ? SW : ts_pkg::COEF_W + 1;
  localparam int PW     = SW + BW;
  localparam logic [PW:0] HALF_G = (PW+1)'(1) << (ts_pkg::COEF_W - 1);
  localparam logic [PW:0] HALF_D = (PW+1)'(1) << (SW - 2);

  logic signed [SW-1:0] x_r;
  logic [EW-1:0]        r_r;
  logic [CHAN_W-1:0]    ch_r;
  logic [EW-1:0]        fenv_r [CHANNELS];
  logic [EW-1:0]        senv_r [CHANNELS];
  logic [EW-1:0]        fe_r;
  logic [EW-1:0]        se_r;
  logic signed [SW-1:0] g_r;
  logic signed [PW-1:0] p_r;
  logic                 out_valid_r;
  logic [CHAN_W-1:0]    chan_out_r;
  logic signed [SW-1:0] sample_out_r;

  logic                 in_fire;
  logic                 out_blocked;
  logic                 wb_out_en;
  logic [SW-1:0]        abs_in;
  logic [EW-1:0]        r_in;
  logic [EW-1:0]        fe_cur;
  logic [EW-1:0]        se_cur;
  logic signed [SW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   env_sum;
  logic [EW-1:0]        env_new;
  logic                 p_neg;
  logic [PW-1:0]        p_mag;
  logic [PW:0]          g_rnd;
  logic [PW:0]          d_rnd;
  logic signed [SW-1:0] g_new;
  logic signed [SW-1:0] d_val;
  logic signed [SW:0]   y_sum;
  logic signed [SW-1:0] y_sat;

  assign in_bus.ready = (ctl.jmp == ts_pkg::JMP_ACCEPT);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_blocked  = out_valid_r && !out_bus.ready;
  assign wb_out_en    = (ctl.wb inside {ts_pkg::WB_OUT, ts_pkg::WB_PASS}) && !out_blocked;

  assign status.in_fire     = in_fire;
  assign status.chan_ok     = ({1'b0, in_bus.chan} < (CHAN_W+1)'(CHANNELS));
  assign status.out_blocked = out_blocked;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.chan_out   = chan_out_r;
  assign out_bus.sample_out = sample_out_r;

  // rectify, most negative sample clips to full scale
  assign abs_in = in_bus.sample_in[SW-1] ? SW'(-in_bus.sample_in) : SW'(in_bus.sample_in);
  assign r_in   = abs_in[SW-1] ? {EW{1'b1}} : abs_in[EW-1:0];

  assign fe_cur = fenv_r[ch_r];
  assign se_cur = senv_r[ch_r];

  // follower as r + c*(env - r) in Q.16, i.e. c*env + (1-c)*r
  always_comb begin
    case (ctl.a_sel)
      ts_pkg::A_FAST_ERR: a_op = $signed({1'b0, fe_cur}) - $signed({1'b0, r_r});
      ts_pkg::A_SLOW_ERR: a_op = $signed({1'b0, se_cur}) - $signed({1'b0, r_r});
      ts_pkg::A_ENV_DIFF: a_op = $signed({1'b0, fe_r}) - $signed({1'b0, se_r});
      ts_pkg::A_GAIN:     a_op = g_r;
      default:            a_op = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      ts_pkg::B_FAST_COEF:
        b_op = $signed(BW'((r_r > fe_cur) ? coef.fast_att : coef.fast_rel));
      ts_pkg::B_SLOW_COEF:
        b_op = $signed(BW'((r_r > se_cur) ? coef.slow_att : coef.slow_rel));
      ts_pkg::B_AMOUNT:   b_op = $signed(BW'(coef.amount));
      ts_pkg::B_SAMPLE:   b_op = BW'(x_r);
      default:            b_op = '0;
    endcase
  end

  assign prod = a_op * b_op;

  assign env_sum = $signed((PW+1)'({r_r, {ts_pkg::COEF_W{1'b0}}})) + (PW+1)'(p_r);
  assign env_new = env_sum[ts_pkg::COEF_W +: EW];

  // round half away from zero on the magnitude
  assign p_neg = p_r[PW-1];
  assign p_mag = p_neg ? PW'(-p_r) : PW'(p_r);
  assign g_rnd = ({1'b0, p_mag} + HALF_G) >> ts_pkg::COEF_W;
  assign d_rnd = ({1'b0, p_mag} + HALF_D) >> (SW - 1);
  assign g_new = p_neg ? -$signed(g_rnd[SW-1:0]) : $signed(g_rnd[SW-1:0]);
  assign d_val = p_neg ? -$signed(d_rnd[SW-1:0]) : $signed(d_rnd[SW-1:0]);

  assign y_sum = (SW+1)'(x_r) + (SW+1)'(d_val);
  assign y_sat = (y_sum[SW] != y_sum[SW-1]) ?
                 (y_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}) :
                 y_sum[SW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r  <= in_bus.sample_in;
      r_r  <= r_in;
      ch_r <= in_bus.chan;
    end
    if (ctl.mul_en) p_r <= prod;
    if (ctl.wb == ts_pkg::WB_FAST) fe_r <= env_new;
    if (ctl.wb == ts_pkg::WB_SLOW) se_r <= env_new;
    if (ctl.wb == ts_pkg::WB_GAIN) g_r  <= g_new;
    if (wb_out_en) begin
      chan_out_r   <= ch_r;
      sample_out_r <= (ctl.wb == ts_pkg::WB_PASS) ? x_r : y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fenv_r[i] <= '0;
        senv_r[i] <= '0;
      end
    end else begin
      if (wb_out_en) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
      if (ctl.wb == ts_pkg::WB_FAST) fenv_r[ch_r] <= env_new;
      if (ctl.wb == ts_pkg::WB_SLOW) senv_r[ch_r] <= env_new;
    end
  end

endmodule

>>> sv/transient_shaper.sv
// channel     dir  handshake     beat payload
// in_bus      in   valid/ready   chan, sample_in (signed)
// out_bus     out  valid/ready   chan_out, sample_out (signed, saturated)
// apb         in   psel/penable  paddr, pwdata -> prdata, pready tied high
//
// one sample at a time; the result is registered in the output register, set by
// four products on the single shared multiplier
// out-of-range channel: sample passed on unchanged by the pass step, envelopes untouched
// the next beat is taken while a result still waits in the output register;
// the last step holds while that register is full and not taken
// reset (sync, active low) zeroes all envelopes and loads default poles
//
// top level of the transient shaper; depends on ts_pkg, ts_chan_if, ts_regs,
// ts_seq and ts_datapath
module transient_shaper #(
  parameter int CHANNELS    = ts_pkg::CHANNELS,
  parameter int SAMPLE_BITS = ts_pkg::SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ts_in_if.sink                     in_bus,
  ts_out_if.source                  out_bus,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ts_pkg::ADDR_W-1:0] paddr,
  input  logic [ts_pkg::DATA_W-1:0] pwdata,
  output logic [ts_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  ts_pkg::coef_t      coef;
  ts_pkg::ctl_t       ctl;
  ts_pkg::dp_status_t status;

  ts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  ts_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  ts_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .coef    (coef),
    .ctl     (ctl),
    .status  (status)
  );

endmodule

>>> sv/ts_checker.sv
// port-level checker for the transient shaper, bound to the top level
// depends on ts_pkg and transient_shaper_assert.svh
`include "transient_shaper_assert.svh"

module ts_checker #(
  parameter int CHAN_W = ts_pkg::CHAN_W,
  parameter int SW     = ts_pkg::SAMPLE_BITS
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_chan,
  input logic [SW-1:0]     out_sample
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // samples accepted whose result beat has not gone out yet
  always_comb begin
    pend_nxt = pend_r;
    if (in_fire && !out_fire) pend_nxt = pend_r + 2'd1;
    else if (!in_fire && out_fire) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `TS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_fire, !in_ready, "beat taken while busy")
  `TS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_chan) && $stable(out_sample), "stalled result changed")
  `TS_ASSERT_IMP(a_pend_max, clk, rst_n, 1'b1, pend_r != 2'd3, "more than two samples in flight")
  `TS_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, pend_r != 2'd0, "result without a sample")
  `TS_ASSERT_ALWAYS_NXT(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind transient_shaper ts_checker #(
  .CHAN_W ((CHANNELS > 1) ? $clog2(CHANNELS) : 1),
  .SW     (SAMPLE_BITS)
) u_ts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_chan   (out_bus.chan_out),
  .out_sample (out_bus.sample_out)
);
